// ----- sv/lpd_pkg.sv -----
// Shared widths, status codes and state type for the length-prefixed deframer.
// No dependencies; the deframer top level, the checker and the testbench import this package.
`default_nettype none

package lpd_pkg;

  localparam int STORE_BYTES_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int ACT_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 3;
  localparam int PKT_W   = 7;
  localparam int LEN_W   = 13;
  localparam int HDR_W   = 3;
  localparam int SHIFT_W = 32;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd1500;
  localparam logic [HDR_W-1:0] HDR_BYTES     = 3'd4;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [ADDR_W-1:0] REG_MAX_LENGTH = 3'd0;

  typedef enum logic [STAT_W-1:0] {
    STAT_PARTIAL  = 3'd0,
    STAT_COMPLETE = 3'd1,
    STAT_TOO_BIG  = 3'd2,
    STAT_OVERFLOW = 3'd3,
    STAT_HELD     = 3'd4,
    STAT_READ     = 3'd5,
    STAT_EMPTY    = 3'd6,
    STAT_CLEARED  = 3'd7
  } lpd_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } lpd_state_t;

endpackage

`default_nettype wire

// ----- sv/lpd_ram.sv -----
// Single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is issued. Uses no package items.
`default_nettype none

module lpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/length_prefixed_deframer.sv -----
// Length-prefixed deframer top level: control, pointers and output register.
// Depends on lpd_pkg and lpd_ram (payload byte store and packet length queue).
`default_nettype none

// Each input word carries an action: push a stream byte, read the next byte of
// the oldest queued packet, or clear. Pushed bytes form packets that open with a
// 4-byte big-endian payload length; payload goes to a circular byte store and
// the length to a circular length queue. Every input word yields exactly one
// result word. Accepting an item launches reads of the byte store (at the read
// pointer) and the length queue (at the entry after the head); the EXEC state
// then does the read-modify-write of pointers, counters and both memories and
// loads the output register. No new word is taken until that step is done; a
// stalled, still-full output register holds the EXEC state. The
// output register lets a new word be accepted while a result waits. Both memories
// start undefined and need no clearing pass: only written entries are ever read.
// An oversize length (too_big) or a packet that does not fit (overflow) sets a
// sticky error that answers pushes with "held" until a clear; reads still drain.
// max_length sits at byte address 0 of the APB port (reset 1500).

module length_prefixed_deframer
  import lpd_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [ACT_W-1:0]   in_action,
  input  wire logic [BYTE_W-1:0]  in_byte,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [STAT_W-1:0]  out_status,
  output logic      [BYTE_W-1:0]  out_byte,
  output logic                    out_last_of_packet,
  output logic      [PKT_W-1:0]   out_packets_waiting,
  output logic      [LEN_W-1:0]   out_head_length,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  localparam int SA_W   = $clog2(STORE_BYTES);      // store address
  localparam int USED_W = $clog2(STORE_BYTES + 1);  // store fill
  localparam int QA_W   = $clog2(QUEUE_DEPTH);      // queue address
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);  // queue count

  // ---------------------------------------------------------------- config
  logic [LEN_W-1:0] max_len_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // register select decodes the word index only
  assign prdata = (paddr[ADDR_W-1] == REG_MAX_LENGTH[ADDR_W-1]) ?
                  DATA_W'(max_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr && (paddr[ADDR_W-1] == REG_MAX_LENGTH[ADDR_W-1])) begin
      max_len_r <= pwdata[LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------- state
  lpd_state_t state_r, state_nxt;

  logic [HDR_W-1:0]   hdr_cnt_r,   hdr_cnt_nxt;
  logic [SHIFT_W-1:0] len_shift_r, len_shift_nxt;
  logic [LEN_W-1:0]   remain_r,    remain_nxt;
  logic [SA_W-1:0]    wr_ptr_r,    wr_ptr_nxt;
  logic [SA_W-1:0]    rd_ptr_r,    rd_ptr_nxt;
  logic [USED_W-1:0]  used_r,      used_nxt;
  logic [QA_W-1:0]    q_head_r,    q_head_nxt;
  logic [QA_W-1:0]    q_tail_r,    q_tail_nxt;
  logic [QC_W-1:0]    q_cnt_r,     q_cnt_nxt;
  logic [LEN_W-1:0]   head_off_r,  head_off_nxt;
  logic               err_r,       err_nxt;
  logic [LEN_W-1:0]   head_len_r,  head_len_nxt;  // cached length at queue head

  // latched input word
  logic [ACT_W-1:0]   act_r;
  logic [BYTE_W-1:0]  byte_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  lpd_status_t        res_status_r, res_status_nxt;
  logic [BYTE_W-1:0]  res_byte_r,   res_byte_nxt;
  logic               res_last_r,   res_last_nxt;
  logic [PKT_W-1:0]   res_pkts_r,   res_pkts_nxt;
  logic [LEN_W-1:0]   res_hlen_r,   res_hlen_nxt;

  logic in_fire;
  logic exec_go;

  // memory ports
  logic               st_we;
  logic [BYTE_W-1:0]  st_rdata;
  logic               lq_we;
  logic [LEN_W-1:0]   lq_wdata;
  logic [LEN_W-1:0]   lq_rdata;
  logic [QA_W-1:0]    head_inc;

  assign head_inc = (q_head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_r + 1'b1;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    exec_go  = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_EXEC: exec_go  = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_fire = in_valid && !in_stall;

  // ---------------------------------------------------------------- memories
  // byte store: read at the read pointer on accept, written by payload pushes
  lpd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (st_we && exec_go),
    .waddr (wr_ptr_r),
    .wdata (byte_r),
    .re    (in_fire),
    .raddr (rd_ptr_r),
    .rdata (st_rdata)
  );

  // length queue: the entry after the head is prefetched so a dequeue can
  // refresh the cached head length in the same execute cycle
  lpd_ram #(
    .WIDTH (LEN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_lenq (
    .clk   (clk),
    .we    (lq_we),
    .waddr (q_tail_r),
    .wdata (lq_wdata),
    .re    (in_fire),
    .raddr (head_inc),
    .rdata (lq_rdata)
  );

  // ---------------------------------------------------------------- execute
  always_comb begin
    logic [SHIFT_W-1:0] shift_v;
    logic [SHIFT_W-1:0] free_v;
    logic [LEN_W-1:0]   remain_dec;
    logic [LEN_W-1:0]   off_inc;
    logic               enq;
    logic               deq;

    shift_v    = {len_shift_r[SHIFT_W-BYTE_W-1:0], byte_r};
    free_v     = SHIFT_W'(USED_W'(STORE_BYTES) - used_r);
    remain_dec = (remain_r != '0) ? remain_r - 1'b1 : '0;
    off_inc    = head_off_r + 1'b1;
    enq        = 1'b0;
    deq        = 1'b0;

    hdr_cnt_nxt   = hdr_cnt_r;
    len_shift_nxt = len_shift_r;
    remain_nxt    = remain_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    used_nxt      = used_r;
    q_head_nxt    = q_head_r;
    q_tail_nxt    = q_tail_r;
    q_cnt_nxt     = q_cnt_r;
    head_off_nxt  = head_off_r;
    err_nxt       = err_r;
    head_len_nxt  = head_len_r;
    st_we         = 1'b0;
    lq_wdata      = '0;

    res_status_nxt = STAT_PARTIAL;
    res_byte_nxt   = '0;
    res_last_nxt   = 1'b0;

    case (act_r)
      ACT_PUSH: begin
        if (err_r) begin
          res_status_nxt = STAT_HELD;
        end else if (hdr_cnt_r < HDR_BYTES) begin
          len_shift_nxt = shift_v;
          hdr_cnt_nxt   = hdr_cnt_r + 1'b1;
          if (hdr_cnt_r != HDR_BYTES - 1'b1) begin
            res_status_nxt = STAT_PARTIAL;
          end else if (shift_v > SHIFT_W'(max_len_r)) begin
            err_nxt        = 1'b1;
            res_status_nxt = STAT_TOO_BIG;
          end else if ((shift_v > free_v) || (q_cnt_r == QC_W'(QUEUE_DEPTH))) begin
            err_nxt        = 1'b1;
            res_status_nxt = STAT_OVERFLOW;
          end else begin
            used_nxt = used_r + shift_v[USED_W-1:0];
            if (shift_v == '0) begin
              // empty packet completes on its last header byte
              enq            = 1'b1;
              lq_wdata       = '0;
              hdr_cnt_nxt    = '0;
              res_status_nxt = STAT_COMPLETE;
            end else begin
              remain_nxt     = shift_v[LEN_W-1:0];
              res_status_nxt = STAT_PARTIAL;
            end
          end
        end else begin
          st_we      = 1'b1;
          wr_ptr_nxt = (wr_ptr_r == SA_W'(STORE_BYTES - 1)) ? '0 : wr_ptr_r + 1'b1;
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            enq            = 1'b1;
            lq_wdata       = len_shift_r[LEN_W-1:0];
            hdr_cnt_nxt    = '0;
            len_shift_nxt  = '0;
            res_status_nxt = STAT_COMPLETE;
          end else begin
            res_status_nxt = STAT_PARTIAL;
          end
        end
      end
      ACT_READ: begin
        if (q_cnt_r == '0) begin
          res_status_nxt = STAT_EMPTY;
        end else begin
          res_status_nxt = STAT_READ;
          if (head_len_r == '0) begin
            res_last_nxt = 1'b1;
            deq          = 1'b1;
          end else begin
            res_byte_nxt = st_rdata;
            rd_ptr_nxt   = (rd_ptr_r == SA_W'(STORE_BYTES - 1)) ? '0 : rd_ptr_r + 1'b1;
            if (used_r != '0) begin
              used_nxt = used_r - 1'b1;
            end
            head_off_nxt = off_inc;
            if (off_inc >= head_len_r) begin
              res_last_nxt = 1'b1;
              deq          = 1'b1;
            end
          end
        end
      end
      ACT_CLEAR: begin
        hdr_cnt_nxt    = '0;
        len_shift_nxt  = '0;
        remain_nxt     = '0;
        wr_ptr_nxt     = '0;
        rd_ptr_nxt     = '0;
        used_nxt       = '0;
        q_head_nxt     = '0;
        q_tail_nxt     = '0;
        q_cnt_nxt      = '0;
        head_off_nxt   = '0;
        err_nxt        = 1'b0;
        res_status_nxt = STAT_CLEARED;
      end
      default: begin
        res_status_nxt = STAT_PARTIAL;
      end
    endcase

    if (enq) begin
      q_tail_nxt = (q_tail_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail_r + 1'b1;
      q_cnt_nxt  = q_cnt_r + 1'b1;
      if (q_cnt_r == '0) begin
        head_len_nxt = lq_wdata;
      end
    end
    if (deq) begin
      q_head_nxt   = head_inc;
      q_cnt_nxt    = q_cnt_r - 1'b1;
      head_off_nxt = '0;
      head_len_nxt = lq_rdata;
    end

    lq_we = enq && exec_go;

    res_pkts_nxt = PKT_W'(q_cnt_nxt);
    res_hlen_nxt = (q_cnt_nxt != '0) ? head_len_nxt : '0;
  end

  assign out_valid_nxt = exec_go || (out_valid_r && out_stall);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hdr_cnt_r   <= '0;
      len_shift_r <= '0;
      remain_r    <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      used_r      <= '0;
      q_head_r    <= '0;
      q_tail_r    <= '0;
      q_cnt_r     <= '0;
      head_off_r  <= '0;
      err_r       <= 1'b0;
      head_len_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        hdr_cnt_r   <= hdr_cnt_nxt;
        len_shift_r <= len_shift_nxt;
        remain_r    <= remain_nxt;
        wr_ptr_r    <= wr_ptr_nxt;
        rd_ptr_r    <= rd_ptr_nxt;
        used_r      <= used_nxt;
        q_head_r    <= q_head_nxt;
        q_tail_r    <= q_tail_nxt;
        q_cnt_r     <= q_cnt_nxt;
        head_off_r  <= head_off_nxt;
        err_r       <= err_nxt;
        head_len_r  <= head_len_nxt;
      end
    end
  end

  // word and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_action;
      byte_r <= in_byte;
    end
    if (exec_go) begin
      res_status_r <= res_status_nxt;
      res_byte_r   <= res_byte_nxt;
      res_last_r   <= res_last_nxt;
      res_pkts_r   <= res_pkts_nxt;
      res_hlen_r   <= res_hlen_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_status_r;
  assign out_byte            = res_byte_r;
  assign out_last_of_packet  = res_last_r;
  assign out_packets_waiting = res_pkts_r;
  assign out_head_length     = res_hlen_r;

endmodule

`default_nettype wire

// ----- sv/lpd_checker.sv -----
// Port-level checker for length_prefixed_deframer, bound to the top level.
// Depends on lpd_pkg for widths and status codes.
`default_nettype none

module lpd_checker
  import lpd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic              out_last_of_packet,
  input wire logic [PKT_W-1:0]  out_packets_waiting,
  input wire logic [LEN_W-1:0]  out_head_length
);

  // an accepted word keeps the input side busy for its execute cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  // end-of-packet flag only on a byte read
  a_last_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_packet |-> out_status == STAT_READ)
    else $error("last flag outside a read");

  // clear and empty read leave nothing queued
  a_empty_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_CLEARED || out_status == STAT_EMPTY) |->
      out_packets_waiting == '0 && out_head_length == '0)
    else $error("queue not empty after clear or empty read");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_last_of_packet  (out_last_of_packet),
  .out_packets_waiting (out_packets_waiting),
  .out_head_length     (out_head_length)
);

`default_nettype wire

// ----- tb/length_prefixed_deframer_tb.sv -----
// Self-checking testbench for length_prefixed_deframer: directed and random word traffic,
// checked against an in-bench model of the deframer. Depends on lpd_pkg and the RTL.
module length_prefixed_deframer_tb;
  import lpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SP_W = $clog2(STORE_BYTES_DEF);  // byte store pointer width
  localparam int QP_W = $clog2(QUEUE_DEPTH_DEF);  // length ring pointer width
  localparam int WATCHDOG_LIMIT = 2000;           // cycles with no word moving
  localparam int MAX_REPORTS = 10;

  // action 3 has no meaning; the block must answer "partial" and change nothing
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    lpd_status_t        status;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [PKT_W-1:0]   waiting;
    logic [LEN_W-1:0]   head_len;
  } deframe_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Everything starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ACT_W-1:0]  in_action = ACT_PUSH;
  logic [BYTE_W-1:0] in_byte = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last_of_packet;
  logic [PKT_W-1:0]  out_packets_waiting;
  logic [LEN_W-1:0]  out_head_length;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  initial begin
    forever #4 clk = ~clk;
  end

  length_prefixed_deframer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_byte            (out_byte),
    .out_last_of_packet  (out_last_of_packet),
    .out_packets_waiting (out_packets_waiting),
    .out_head_length     (out_head_length),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // ---------------------------------------------------------------------------
  // Deframer model state, kept at the block's widths. Pointers wrap naturally
  // because both store sizes are powers of two.
  // ---------------------------------------------------------------------------
  logic [HDR_W-1:0]   hdr_seen;        // header bytes taken for the open packet
  logic [SHIFT_W-1:0] len_shift;       // big-endian length being assembled
  logic [LEN_W-1:0]   payload_left;
  logic [BYTE_W-1:0]  byte_store [STORE_BYTES_DEF];
  logic [SP_W-1:0]    store_wr;
  logic [SP_W-1:0]    store_rd;
  logic [LEN_W-1:0]   bytes_reserved;  // grows at header time, shrinks per read
  logic [LEN_W-1:0]   len_ring [QUEUE_DEPTH_DEF];
  logic [QP_W-1:0]    len_wr;
  logic [QP_W-1:0]    len_rd;
  logic [PKT_W-1:0]   pkt_count;
  logic [LEN_W-1:0]   head_off;        // bytes already read from the head packet
  logic               err_held;        // sticky too_big / overflow
  logic [LEN_W-1:0]   max_len = MAX_LEN_RESET;

  deframe_result_t pending_results[$];  // expected results, oldest first
  int failures = 0;
  int words_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;                   // random gaps / stalls enabled

  // clear does not touch max_len
  function automatic void clear_deframer();
    hdr_seen = '0;
    len_shift = '0;
    payload_left = '0;
    store_wr = '0;
    store_rd = '0;
    bytes_reserved = '0;
    len_wr = '0;
    len_rd = '0;
    pkt_count = '0;
    head_off = '0;
    err_held = 1'b0;
  endfunction

  function automatic void queue_length(input logic [SHIFT_W-1:0] len);
    len_ring[len_wr] = LEN_W'(len);
    len_wr++;
    pkt_count++;
  endfunction

  function automatic void retire_head();
    len_rd++;
    pkt_count--;
    head_off = '0;
  endfunction

  // Next-state and result for one accepted input word.
  function automatic deframe_result_t deframe_step(input logic [ACT_W-1:0] act,
                                                   input logic [BYTE_W-1:0] b);
    deframe_result_t r;
    logic [LEN_W-1:0] head_len;
    r = '0;
    r.status = STAT_PARTIAL;
    case (act)
      ACT_PUSH: begin
        if (err_held) begin
          r.status = STAT_HELD;
        end else if (hdr_seen < HDR_BYTES) begin
          len_shift = {len_shift[SHIFT_W-9:0], b};
          hdr_seen++;
          if (hdr_seen == HDR_BYTES) begin
            if (len_shift > max_len) begin
              err_held = 1'b1;
              r.status = STAT_TOO_BIG;
            end else if (len_shift > (STORE_BYTES_DEF - bytes_reserved) ||
                         pkt_count >= QUEUE_DEPTH_DEF) begin
              err_held = 1'b1;
              r.status = STAT_OVERFLOW;
            end else begin
              bytes_reserved = bytes_reserved + LEN_W'(len_shift);
              if (len_shift == 0) begin
                // empty packet completes on its last header byte
                queue_length('0);
                hdr_seen = '0;
                r.status = STAT_COMPLETE;
              end else begin
                payload_left = LEN_W'(len_shift);
              end
            end
          end
        end else begin
          byte_store[store_wr] = b;
          store_wr++;
          if (payload_left != 0) payload_left--;
          if (payload_left == 0) begin
            queue_length(len_shift);
            hdr_seen = '0;
            len_shift = '0;
            r.status = STAT_COMPLETE;
          end
        end
      end
      ACT_READ: begin
        if (pkt_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          head_len = len_ring[len_rd];
          r.status = STAT_READ;
          if (head_len == 0) begin
            // empty packet: one read removes it, data reads as zero
            r.last = 1'b1;
            retire_head();
          end else begin
            r.data = byte_store[store_rd];
            store_rd++;
            if (bytes_reserved != 0) bytes_reserved--;
            head_off++;
            if (head_off >= head_len) begin
              r.last = 1'b1;
              retire_head();
            end
          end
        end
      end
      ACT_CLEAR: begin
        clear_deframer();
        r.status = STAT_CLEARED;
      end
      default: ;
    endcase
    r.waiting = pkt_count;
    r.head_len = (pkt_count != 0) ? len_ring[len_rd] : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result word against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    deframe_result_t got;
    deframe_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{status: lpd_status_t'(out_status), data: out_byte,
              last: out_last_of_packet, waiting: out_packets_waiting,
              head_len: out_head_length};
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result word: status=%0d byte=%02h last=%0b waiting=%0d head=%0d",
                   got.status, got.data, got.last, got.waiting, got.head_len);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected: status=%0d byte=%02h last=%0b waiting=%0d head=%0d",
                     want.status, want.data, want.last, want.waiting, want.head_len);
            $display("  actual:   status=%0d byte=%02h last=%0b waiting=%0d head=%0d",
                     got.status, got.data, got.last, got.waiting, got.head_len);
          end
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
    out_stall <= (stall_left > 0);
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one input word, optionally after a short gap. Valid is only lowered
  // for a gap, so back-to-back words keep it high without a glitch.
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(deframe_step(act, b));
    words_sent++;
  endtask

  task automatic send_header(input logic [SHIFT_W-1:0] len);
    for (int i = 3; i >= 0; i--) send_word(ACT_PUSH, len[8*i +: 8]);
  endtask

  task automatic read_words(input int n);
    repeat (n) send_word(ACT_READ, BYTE_W'($urandom));
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of max_length with the block idle, then read it back.
  task automatic set_max_length(input int unsigned value);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * REG_MAX_LENGTH);
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    max_len = LEN_W'(value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LEN_W-1:0] !== max_len) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("max_length readback: expected %0d, actual %0d", max_len, prdata[LEN_W-1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every action, empty queue, empty packet, extreme payload bytes, clear mid-header.
  task automatic test_basic_actions();
    read_words(1);                      // empty queue
    send_word(ACT_UNUSED, 8'hFF);       // ignored
    send_header(32'd0);                 // empty packet completes on header
    send_header(32'd2);
    send_word(ACT_PUSH, 8'h00);
    send_word(ACT_PUSH, 8'hFF);
    read_words(4);                      // empty packet, two bytes, then empty
    send_word(ACT_PUSH, 8'h00);
    send_word(ACT_PUSH, 8'h00);
    send_word(ACT_CLEAR, 8'h55);        // drops the half header
    send_header(32'd1);
    send_word(ACT_PUSH, 8'hA5);
    read_words(2);
  endtask

  // Lengths at and around max_length, sticky too_big, reads while held.
  task automatic test_length_limits();
    set_max_length(0);
    send_header(32'd0);
    send_header(32'd1);                 // too_big
    send_word(ACT_PUSH, 8'hAA);         // held
    read_words(2);                      // queue still drains
    send_word(ACT_CLEAR, 8'h00);
    set_max_length(3);
    send_header(32'd3);
    repeat (3) send_word(ACT_PUSH, BYTE_W'($urandom));
    read_words(3);
    send_header(32'd4);                 // one above the limit
    send_word(ACT_CLEAR, 8'h00);
    set_max_length(STORE_BYTES_DEF);
    send_header(32'h0000_1001);
    send_word(ACT_CLEAR, 8'h00);
    send_header(32'hFFFF_FFFF);         // every length bit set
    send_word(ACT_CLEAR, 8'h00);
    send_header(32'h0100_0000);
    send_word(ACT_CLEAR, 8'h00);
  endtask

  // Byte store full: one queued byte leaves no room for a full-size packet.
  task automatic test_store_overflow();
    send_header(32'd1);
    send_word(ACT_PUSH, 8'h5A);
    send_header(STORE_BYTES_DEF);       // overflow
    send_word(ACT_PUSH, 8'h11);         // held
    read_words(2);
    send_word(ACT_CLEAR, 8'h00);
  endtask

  // Length queue full of empty packets, then one more header; drain wraps the ring.
  task automatic test_queue_full();
    repeat (QUEUE_DEPTH_DEF) send_header(32'd0);
    send_header(32'd0);                 // overflow: no queue entry left
    read_words(QUEUE_DEPTH_DEF + 1);
    send_word(ACT_CLEAR, 8'h00);
  endtask

  // Mostly well-formed packets with random content and interleaved reads,
  // mixed with clears, ignored words, junk headers and stray bytes.
  task automatic test_random_traffic();
    int unsigned phase_max [4];
    int budget;
    int start;
    int pick;
    int len;
    phase_max = '{300, $urandom_range(8, 64), 150, 300};
    budget = 120;
    for (int phase = 0; phase < 4; phase++) begin
      set_max_length(phase_max[phase]);  // sender waits for all results here
      if (phase == 3) idle_on = 1'b0;    // last stretch runs at full rate
      start = words_sent;
      while (words_sent - start < budget) begin
        if (err_held && $urandom_range(0, 1) == 0) begin
          send_word(ACT_CLEAR, BYTE_W'($urandom));
          continue;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) len = int'(max_len);
          else if (pick < 3) len = $urandom_range(25, 300);
          else len = $urandom_range(0, 24);
          send_header(len);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) read_words(1);
            send_word(ACT_PUSH, BYTE_W'($urandom));
          end
        end else if (pick < 80) begin
          read_words($urandom_range(1, 6));
        end else if (pick < 85) begin
          send_word(ACT_CLEAR, BYTE_W'($urandom));
        end else if (pick < 90) begin
          send_word(ACT_UNUSED, BYTE_W'($urandom));
        end else if (pick < 95) begin
          send_header($urandom);        // junk length, nearly always too_big
        end else begin
          send_word(ACT_PUSH, BYTE_W'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_deframer();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_actions();
    test_length_limits();
    test_store_overflow();
    test_queue_full();
    test_random_traffic();

    // the watchdog bounds this wait
    drain_results();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
